### design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared opcodes, state encoding and the controller/datapath signal bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

	localparam int ResNumW = 33;
	localparam int ResDenW = 31;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT  = 4'd4, OP_GE  = 4'd5, OP_LT  = 4'd6, OP_LE  = 4'd7,
		OP_EQ  = 4'd8, OP_NE  = 4'd9
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_FORM, ST_GCD_LOAD, ST_GCD_RUN,
		ST_GCD_CHECK, ST_DIVN_LOAD, ST_DIVN_RUN, ST_DIVD_LOAD, ST_DIVD_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic form;
		logic div_load_gcd;
		logic div_load_n;
		logic div_load_d;
		logic div_step;
		logic gcd_swap;
		logic save_n;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_arith;
		logic den_zero;
		logic div_done;
		logic rem_zero;
	} sts_t;

endpackage
`default_nettype wire

### design/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: cross products, then (arithmetic, nonzero denominator) Euclid
// loop on a shared divider, two exact gcd divisions, then one result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl
	import rau_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_d = ST_MUL1;
			ST_MUL1:      state_d = ST_MUL2;
			ST_MUL2:      state_d = ST_FORM;
			ST_FORM: begin
				if (!sts.is_arith || sts.den_zero) state_d = ST_DONE;
				else state_d = ST_GCD_LOAD;
			end
			ST_GCD_LOAD:  state_d = ST_GCD_RUN;
			ST_GCD_RUN:   if (sts.div_done) state_d = ST_GCD_CHECK;
			ST_GCD_CHECK: begin
				if (sts.rem_zero) state_d = ST_DIVN_LOAD;
				else state_d = ST_GCD_RUN;
			end
			ST_DIVN_LOAD: state_d = ST_DIVN_RUN;
			ST_DIVN_RUN:  if (sts.div_done) state_d = ST_DIVD_LOAD;
			ST_DIVD_LOAD: state_d = ST_DIVD_RUN;
			ST_DIVD_RUN:  if (sts.div_done) state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:      cmd.load = start;
			ST_MUL1:      cmd.mul1 = 1'b1;
			ST_MUL2:      cmd.mul2 = 1'b1;
			ST_FORM:      cmd.form = 1'b1;
			ST_GCD_LOAD:  cmd.div_load_gcd = 1'b1;
			ST_GCD_RUN:   cmd.div_step = 1'b1;
			ST_GCD_CHECK: cmd.gcd_swap = !sts.rem_zero;
			ST_DIVN_LOAD: cmd.div_load_n = 1'b1;
			ST_DIVN_RUN:  begin
				cmd.div_step = 1'b1;
				cmd.save_n = sts.div_done;
			end
			ST_DIVD_LOAD: cmd.div_load_d = 1'b1;
			ST_DIVD_RUN:  cmd.div_step = 1'b1;
			ST_DONE:      cmd.emit = 1'b1;
			default:      cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### design/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: one shared multiplier, operand registers, and a restoring
// divider that serves both the gcd loop and the final reductions.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_dp
	import rau_pkg::*;
#(
	parameter int FIELD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [3:0]                    op,
	input  wire logic signed [FIELD_WIDTH-1:0] a_num,
	input  wire logic [FIELD_WIDTH-2:0]        a_den,
	input  wire logic signed [FIELD_WIDTH-1:0] b_num,
	input  wire logic [FIELD_WIDTH-2:0]        b_den,
	input  wire cmd_t                          cmd,
	output sts_t                               sts,
	output logic                               done,
	output logic signed [ResNumW-1:0]          res_num,
	output logic [ResDenW-1:0]                 res_den,
	output logic                               cmp_true,
	output logic                               div_error
);

	localparam int PW = 2 * FIELD_WIDTH;
	localparam int SW = PW + 2;
	localparam int MW = PW + 1;
	localparam int CW = $clog2(MW + 1);

	logic [3:0]                    op_q;
	logic signed [FIELD_WIDTH-1:0] an_q, bn_q;
	logic signed [FIELD_WIDTH:0]   ad_q, bd_q;
	logic signed [PW-1:0]          p1_q, p2_q;
	logic signed [SW-1:0]          rn_q, rd_q;
	logic                          neg_q;
	logic [MW-1:0]                 n_q, g_q, qn_q;
	logic [MW-1:0]                 dvd_q, dvs_q, quo_q;
	logic [MW:0]                   rem_q;
	logic [CW-1:0]                 cnt_q;
	logic                          run_q;

	logic signed [FIELD_WIDTH:0] mx, my;
	logic signed [PW+1:0]        prod;
	logic signed [SW-1:0]        sn, sd;
	logic [MW:0]                 rem_sh;
	logic [MW-1:0]               mag_n, mag_d;

	always_comb begin
		mx = {an_q[FIELD_WIDTH-1], an_q};
		my = bd_q;
		if (cmd.mul1 && op_q == OP_MUL) my = {bn_q[FIELD_WIDTH-1], bn_q};
		if (cmd.mul2) begin
			mx = ad_q;
			my = (op_q <= OP_MUL) ? bd_q : {bn_q[FIELD_WIDTH-1], bn_q};
		end
		if (cmd.form) begin
			mx = ad_q;
			my = {bn_q[FIELD_WIDTH-1], bn_q};
		end
		prod = mx * my;
	end

	always_comb begin
		sn = SW'(p1_q);
		sd = SW'(p2_q);
		unique case (op_q)
			OP_ADD: begin
				sn = SW'(p1_q) + prod;
				sd = SW'(p2_q);
			end
			OP_SUB: begin
				sn = SW'(p1_q) - prod;
				sd = SW'(p2_q);
			end
			default: begin
				sn = SW'(p1_q);
				sd = SW'(p2_q);
			end
		endcase
	end

	assign mag_n = rn_q[SW-1] ? MW'(-rn_q) : MW'(rn_q);
	assign mag_d = rd_q[SW-1] ? MW'(-rd_q) : MW'(rd_q);
	assign rem_sh = {rem_q[MW-1:0], dvd_q[MW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			an_q <= a_num;
			bn_q <= b_num;
			ad_q <= {2'b00, a_den};
			bd_q <= {2'b00, b_den};
		end
		if (cmd.mul1) p1_q <= PW'(prod);
		if (cmd.mul2) p2_q <= PW'(prod);
		if (cmd.form) begin
			rn_q <= sn;
			rd_q <= sd;
		end
		if (cmd.div_load_gcd) begin
			n_q <= mag_d;
			neg_q <= rn_q[SW-1] ^ rd_q[SW-1];
		end
		if (cmd.gcd_swap) begin
			n_q <= rem_q[MW-1:0];
		end
		if (cmd.save_n) qn_q <= quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.div_load_gcd || cmd.gcd_swap || cmd.div_load_n
				|| cmd.div_load_d) begin
			run_q <= 1'b1;
			cnt_q <= CW'(MW);
		end else if (cmd.div_step && run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load_gcd) begin
			dvd_q <= mag_n;
			dvs_q <= mag_d;
			rem_q <= '0;
		end else if (cmd.gcd_swap) begin
			dvd_q <= n_q;
			dvs_q <= rem_q[MW-1:0];
			rem_q <= '0;
		end else if (cmd.div_load_n) begin
			dvs_q <= n_q;
			g_q <= n_q;
			rem_q <= '0;
			dvd_q <= mag_n;
		end else if (cmd.div_load_d) begin
			dvd_q <= mag_d;
			dvs_q <= g_q;
			rem_q <= '0;
		end else if (cmd.div_step && run_q) begin
			dvd_q <= {dvd_q[MW-2:0], 1'b0};
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[MW-2:0], 1'b0};
			end
		end
	end

	assign sts.is_arith = (op_q <= OP_DIV);
	assign sts.den_zero = (sd == '0);
	assign sts.div_done = !run_q;
	assign sts.rem_zero = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			res_num <= '0;
			res_den <= '0;
			cmp_true <= 1'b0;
			div_error <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.emit) begin
				res_num <= '0;
				res_den <= '0;
				cmp_true <= 1'b0;
				div_error <= 1'b0;
				if (op_q <= OP_DIV) begin
					if (rd_q == '0) begin
						div_error <= 1'b1;
					end else begin
						res_num <= neg_q ? ResNumW'(-{1'b0, qn_q}) : ResNumW'(qn_q);
						res_den <= ResDenW'(quo_q);
					end
				end else begin
					unique case (op_q)
						OP_GT:   cmp_true <= (rn_q > rd_q);
						OP_GE:   cmp_true <= (rn_q >= rd_q);
						OP_LT:   cmp_true <= (rn_q < rd_q);
						OP_LE:   cmp_true <= (rn_q <= rd_q);
						OP_EQ:   cmp_true <= (rn_q == rd_q);
						OP_NE:   cmp_true <= (rn_q != rd_q);
						default: cmp_true <= 1'b0;
					endcase
				end
			end
		end
	end

endmodule
`default_nettype wire

### design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction ALU with gcd reduction: add, sub, mul, div and six compares.
// ----------------------------------------------------------------------------
// Usage: drive op and the two fractions and raise start while busy is low;
// the transfer happens at that edge and busy rises the next cycle.
// Cross products run on one shared multiplier in states MUL1, MUL2 and FORM,
// the last also forming the sum. Comparisons, and arithmetic ops with a zero
// denominator, finish there: FORM goes to DONE, whose emit strobe registers
// done. Arithmetic ops run Euclid on a shared bit-serial divider, then two
// exact divisions by the gcd. busy is low in the cycle done is high, so the
// next transfer can land at the edge that ends it; start is ignored while
// busy is high, so a new item is taken only after the last is finished.
// The result is registered onto res_num, res_den, cmp_true and div_error
// with done and holds until the next done; the receiver cannot stall it.
// Reset clears the controller and output strobe; no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int FIELD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [3:0]                    op,
	input  wire logic signed [FIELD_WIDTH-1:0] a_num,
	input  wire logic [FIELD_WIDTH-2:0]        a_den,
	input  wire logic signed [FIELD_WIDTH-1:0] b_num,
	input  wire logic [FIELD_WIDTH-2:0]        b_den,
	output logic                               done,
	output logic signed [ResNumW-1:0]          res_num,
	output logic [ResDenW-1:0]                 res_den,
	output logic                               cmp_true,
	output logic                               div_error
);

	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rau_dp #(.FIELD_WIDTH(FIELD_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.res_num   (res_num),
		.res_den   (res_den),
		.cmp_true  (cmp_true),
		.div_error (div_error)
	);

endmodule
`default_nettype wire
